[hw/rtl/irpd_pkg.sv]
// Shared types, constants and the window compare for the IR pulse-distance decoder.
package irpd_pkg;

    localparam int unsigned TICK_W  = 16;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned Q_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_HDR_BURST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_GAP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_BURST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_GAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_GAP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd5;

    localparam logic [TICK_W-1:0] RST_HDR_BURST = 16'd4500;
    localparam logic [TICK_W-1:0] RST_HDR_GAP   = 16'd4500;
    localparam logic [TICK_W-1:0] RST_BIT_BURST = 16'd560;
    localparam logic [TICK_W-1:0] RST_ONE_GAP   = 16'd1690;
    localparam logic [TICK_W-1:0] RST_ZERO_GAP  = 16'd560;
    localparam logic [TICK_W-1:0] RST_TOLERANCE = 16'd500;

    typedef enum logic [2:0] {
        PH_WAKE      = 3'd0,
        PH_HDR_BURST = 3'd1,
        PH_HDR_GAP   = 3'd2,
        PH_BIT_BURST = 3'd3,
        PH_BIT_GAP   = 3'd4,
        PH_STOP      = 3'd5
    } t_phase;

    // Window hits of one interval against every nominal duration.
    typedef struct packed {
        logic hdr_burst;
        logic hdr_gap;
        logic bit_burst;
        logic zero_gap;
        logic one_gap;
    } t_cls;

    // Inclusive window of nominal +/- tolerance, saturating at both ends.
    function automatic logic in_window(input logic [TICK_W-1:0] t,
                                       input logic [TICK_W-1:0] nom,
                                       input logic [TICK_W-1:0] tol);
        logic [TICK_W:0]   sum;
        logic [TICK_W-1:0] lo;
        logic [TICK_W-1:0] hi;
        sum = {1'b0, nom} + {1'b0, tol};
        hi  = sum[TICK_W] ? {TICK_W{1'b1}} : sum[TICK_W-1:0];
        lo  = (nom > tol) ? nom - tol : '0;
        return (t >= lo) && (t <= hi);
    endfunction

endpackage

[hw/rtl/ir_pulse_distance_decoder.sv]
// Top level of the IR pulse-distance frame decoder.
//
// The slave stream carries one interval per transaction: the timer ticks
// between two consecutive receiver edges. Each frame attempt discards one
// wake-up interval, checks the header burst and gap, decodes FRAME_BITS bit
// slots LSB first and closes on a stop interval, whose transaction on the
// master stream carries the word with status 0. A rejected header ends the
// attempt at once and sends the unchanged word with status 1. All other
// intervals produce no output transaction.
// The configuration channel writes the six 16-bit window registers and is
// always ready; registers are only to be changed while the decoder is idle,
// which the block does not enforce. Throughput is one interval per clock
// while the master side does not stall. The front end classifies an interval
// in the cycle it is accepted and pushes it into a two-entry queue; the back
// end pops one entry per cycle unless its result is blocked. When the master
// side stalls, the back end keeps consuming intervals that produce no output.
// An interval that owes the next result waits at the head of the queue, one
// more is accepted behind it, then s_axis_tready drops until the output
// register frees. Reset clears the queue, the output valid flag and the frame
// state; the word store and all window registers get their reset values.
module ir_pulse_distance_decoder
    import irpd_pkg::*;
#(
    parameter int unsigned FRAME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Interval input.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,  // [15:0] interval
    // Decoded frame output.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,  // [31:0] frame_word
    output logic [0:0]           m_axis_tuser,  // [0] status
    // Configuration writes.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    t_cls cls;
    t_cls q_data;
    logic q_ready;
    logic q_valid;
    logic q_pop;
    logic res_status;

    irpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_interval  (s_axis_tdata),
        .o_cls       (cls)
    );

    irpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_data  (cls),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign s_axis_tready = q_ready;

    irpd_back #(
        .FRAME_BITS (FRAME_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_data     (q_data),
        .o_q_pop      (q_pop),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_res_word   (m_axis_tdata),
        .o_res_status (res_status)
    );

    assign m_axis_tuser = res_status;

endmodule

[hw/rtl/irpd_front.sv]
// Front end: configuration registers and window classification of each interval.
module irpd_front
    import irpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TICK_W-1:0]    i_cfg_data,
    input  logic [TICK_W-1:0]    i_interval,
    output t_cls                 o_cls
);

    logic [TICK_W-1:0] r_hdr_burst;
    logic [TICK_W-1:0] r_hdr_gap;
    logic [TICK_W-1:0] r_bit_burst;
    logic [TICK_W-1:0] r_one_gap;
    logic [TICK_W-1:0] r_zero_gap;
    logic [TICK_W-1:0] r_tolerance;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_burst <= RST_HDR_BURST;
            r_hdr_gap   <= RST_HDR_GAP;
            r_bit_burst <= RST_BIT_BURST;
            r_one_gap   <= RST_ONE_GAP;
            r_zero_gap  <= RST_ZERO_GAP;
            r_tolerance <= RST_TOLERANCE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_HDR_BURST: r_hdr_burst <= i_cfg_data;
                REG_HDR_GAP:   r_hdr_gap   <= i_cfg_data;
                REG_BIT_BURST: r_bit_burst <= i_cfg_data;
                REG_ONE_GAP:   r_one_gap   <= i_cfg_data;
                REG_ZERO_GAP:  r_zero_gap  <= i_cfg_data;
                REG_TOLERANCE: r_tolerance <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cls.hdr_burst = in_window(i_interval, r_hdr_burst, r_tolerance);
        o_cls.hdr_gap   = in_window(i_interval, r_hdr_gap,   r_tolerance);
        o_cls.bit_burst = in_window(i_interval, r_bit_burst, r_tolerance);
        o_cls.zero_gap  = in_window(i_interval, r_zero_gap,  r_tolerance);
        o_cls.one_gap   = in_window(i_interval, r_one_gap,   r_tolerance);
    end

endmodule

[hw/rtl/irpd_queue.sv]
// Two-entry queue of classified intervals between the front and back ends.
module irpd_queue
    import irpd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cls o_data
);

    localparam int unsigned PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

    t_cls             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_count != CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!do_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[hw/rtl/irpd_back.sv]
// Back end: frame state machine, bit assembly and the result output register.
module irpd_back
    import irpd_pkg::*;
#(
    parameter int unsigned FRAME_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_cls              i_q_data,
    output logic              o_q_pop,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic [WORD_W-1:0] o_res_word,
    output logic              o_res_status
);

    localparam int unsigned CNT_W = $clog2(FRAME_BITS + 1);

    t_phase            r_phase, n_phase;
    logic [CNT_W-1:0]  r_slot, n_slot;
    logic [WORD_W-1:0] r_word, n_word;
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_word, n_out_word;
    logic              r_out_status, n_out_status;

    logic              out_free;
    logic              need_out;
    logic [CNT_W-1:0]  slot_inc;
    t_phase            slot_end_phase;
    logic [WORD_W-1:0] bit_mask;

    assign out_free       = !r_out_valid || i_res_ready;
    assign slot_inc       = r_slot + 1'b1;
    assign slot_end_phase = (slot_inc >= CNT_W'(FRAME_BITS)) ? PH_STOP : PH_BIT_BURST;
    assign bit_mask       = WORD_W'(1) << r_slot;

    always_comb begin
        case (r_phase)
            PH_HDR_BURST: need_out = !i_q_data.hdr_burst;
            PH_HDR_GAP:   need_out = !i_q_data.hdr_gap;
            PH_STOP:      need_out = 1'b1;
            default:      need_out = 1'b0;
        endcase
    end

    assign o_q_pop = i_q_valid && (!need_out || out_free);

    always_comb begin
        n_phase      = r_phase;
        n_slot       = r_slot;
        n_word       = r_word;
        n_out_valid  = r_out_valid && !i_res_ready;
        n_out_word   = r_out_word;
        n_out_status = r_out_status;
        if (o_q_pop) begin
            case (r_phase)
                PH_HDR_BURST: begin
                    if (i_q_data.hdr_burst) begin
                        n_phase = PH_HDR_GAP;
                    end else begin
                        n_phase      = PH_WAKE;
                        n_out_valid  = 1'b1;
                        n_out_word   = r_word;
                        n_out_status = 1'b1;
                    end
                end
                PH_HDR_GAP: begin
                    if (i_q_data.hdr_gap) begin
                        n_slot  = '0;
                        n_phase = PH_BIT_BURST;
                    end else begin
                        n_phase      = PH_WAKE;
                        n_out_valid  = 1'b1;
                        n_out_word   = r_word;
                        n_out_status = 1'b1;
                    end
                end
                PH_BIT_BURST: begin
                    if (i_q_data.bit_burst) begin
                        n_phase = PH_BIT_GAP;
                    end else begin
                        n_slot  = slot_inc;
                        n_phase = slot_end_phase;
                    end
                end
                PH_BIT_GAP: begin
                    // The zero window wins when both windows overlap.
                    if (i_q_data.zero_gap) begin
                        n_word = r_word & ~bit_mask;
                    end else if (i_q_data.one_gap) begin
                        n_word = r_word | bit_mask;
                    end
                    n_slot  = slot_inc;
                    n_phase = slot_end_phase;
                end
                PH_STOP: begin
                    n_phase      = PH_WAKE;
                    n_out_valid  = 1'b1;
                    n_out_word   = r_word;
                    n_out_status = 1'b0;
                end
                default: begin
                    n_phase = PH_HDR_BURST;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAKE;
            r_slot      <= '0;
            r_word      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_slot      <= n_slot;
            r_word      <= n_word;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word   <= n_out_word;
        r_out_status <= n_out_status;
    end

    assign o_res_valid  = r_out_valid;
    assign o_res_word   = r_out_word;
    assign o_res_status = r_out_status;

endmodule

[hw/rtl/irpd_checker.sv]
// Port-level checker for the IR pulse-distance decoder, bound to the top level.
module irpd_checker
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [31:0]          m_axis_tdata,
    input logic [0:0]           m_axis_tuser,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready
);

    // A stalled result keeps its word and status.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // No result can reach the output straight after reset.
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid ##1 !m_axis_tvalid)
        else $error("result too soon after reset");

    // The input side only backs up when the output side was blocked.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output stall");

    // Configuration writes are never refused out of reset.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write refused");

endmodule

bind ir_pulse_distance_decoder irpd_checker u_irpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready)
);

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the IR pulse-distance frame decoder.
module tb
    import irpd_pkg::*;
();

    localparam int SETTINGS_TOTAL = 6;
    localparam int ITEMS_PER_SETTING = 250;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SLOTS = 32;

    // Indexes past the last window register; the decoder must ignore them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [31:0] word;
        logic        status;
    } t_frame_result;

    // Tracks the decoder state and the frame words still owed on the master side.
    class frame_scoreboard;
        logic [15:0]   regs [6];
        t_phase        ph;
        logic [5:0]    slot;
        logic [31:0]   word_q;
        t_frame_result pending [$];
        int            errors;

        function new();
            regs[REG_HDR_BURST] = RST_HDR_BURST;
            regs[REG_HDR_GAP]   = RST_HDR_GAP;
            regs[REG_BIT_BURST] = RST_BIT_BURST;
            regs[REG_ONE_GAP]   = RST_ONE_GAP;
            regs[REG_ZERO_GAP]  = RST_ZERO_GAP;
            regs[REG_TOLERANCE] = RST_TOLERANCE;
            ph = PH_WAKE;
            slot = '0;
            word_q = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            if (idx <= REG_TOLERANCE) begin
                regs[idx] = val;
            end
        endfunction

        // Inclusive window around a nominal, clipped to the tick range.
        function void bounds(input logic [15:0] nom, output int lo, output int hi);
            lo = int'(nom) - int'(regs[REG_TOLERANCE]);
            hi = int'(nom) + int'(regs[REG_TOLERANCE]);
            if (lo < 0) lo = 0;
            if (hi > 65535) hi = 65535;
        endfunction

        function bit hit(logic [15:0] t, logic [15:0] nom);
            int lo, hi;
            bounds(nom, lo, hi);
            return (int'(t) >= lo) && (int'(t) <= hi);
        endfunction

        function logic [15:0] pick_in(logic [15:0] nom);
            int lo, hi;
            bounds(nom, lo, hi);
            return 16'($urandom_range(hi, lo));
        endfunction

        // Falls back to any value when the window covers the whole range.
        function logic [15:0] pick_out(logic [15:0] nom);
            int lo, hi;
            bounds(nom, lo, hi);
            if (lo > 0 && (hi == 65535 || $urandom_range(0, 1) == 0)) begin
                return 16'($urandom_range(lo - 1, 0));
            end else if (hi < 65535) begin
                return 16'($urandom_range(65535, hi + 1));
            end
            return 16'($urandom);
        endfunction

        function void push_result(logic status);
            t_frame_result r;
            r.word = word_q;
            r.status = status;
            pending.push_back(r);
        endfunction

        function void close_slot();
            slot = slot + 6'd1;
            ph = (slot >= 6'(SLOTS)) ? PH_STOP : PH_BIT_BURST;
        endfunction

        // Advances the decoder state by one accepted interval.
        function void note_interval(logic [15:0] t);
            logic [31:0] mask;
            mask = 32'd1 << slot[4:0];
            case (ph)
                PH_HDR_BURST: begin
                    if (hit(t, regs[REG_HDR_BURST])) begin
                        ph = PH_HDR_GAP;
                    end else begin
                        ph = PH_WAKE;
                        push_result(1'b1);
                    end
                end
                PH_HDR_GAP: begin
                    if (hit(t, regs[REG_HDR_GAP])) begin
                        slot = '0;
                        ph = PH_BIT_BURST;
                    end else begin
                        ph = PH_WAKE;
                        push_result(1'b1);
                    end
                end
                PH_BIT_BURST: begin
                    if (hit(t, regs[REG_BIT_BURST])) ph = PH_BIT_GAP;
                    else close_slot();
                end
                PH_BIT_GAP: begin
                    if (hit(t, regs[REG_ZERO_GAP])) word_q = word_q & ~mask;
                    else if (hit(t, regs[REG_ONE_GAP])) word_q = word_q | mask;
                    close_slot();
                end
                PH_STOP: begin
                    ph = PH_WAKE;
                    push_result(1'b0);
                end
                default: begin
                    ph = PH_HDR_BURST;
                end
            endcase
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [31:0] word, logic status);
            t_frame_result exp_r;
            if (pending.size() == 0) begin
                report($sformatf("unexpected frame word %08h status %0d", word, status));
            end else begin
                exp_r = pending.pop_front();
                if (word !== exp_r.word) begin
                    report($sformatf("frame word %08h, wanted %08h", word, exp_r.word));
                end
                if (status !== exp_r.status) begin
                    report($sformatf("status %0d, wanted %0d", status, exp_r.status));
                end
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [31:0]          m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;

    frame_scoreboard sb = new();

    int  cycles = 0;
    int  items_sent = 0;
    bit  src_idle_en = 1'b0;
    bit  quiet = 1'b0;
    bit  sink_stall_en = 1'b1;
    int  sink_stall_left = 0;

    ir_pulse_distance_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [15:0] interval
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] frame_word
        .m_axis_tuser  (m_axis_tuser),   // [0] status
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Free-running 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The run is abandoned if it goes far beyond the slowest legal schedule.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("ir_pulse_distance_decoder: mismatch");
            $finish;
        end
    end

    // Receiver side: random stall bursts, with stretches where the stall
    // pattern is switched off, and none at all in the last part of the run.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) sink_stall_en = !sink_stall_en;
        if (sink_stall_left > 0) begin
            sink_stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!quiet && sink_stall_en && $urandom_range(0, 4) == 0) begin
            sink_stall_left = $urandom_range(1, 4) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Every output transaction is checked against the oldest expected frame.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser[0]);
        end
    end

    // Offers one interval, possibly after an idle burst, and returns at the
    // clock edge where the transaction completes. tvalid stays high when the
    // next call offers its interval right away.
    task send_interval(logic [15:0] t);
        if (src_idle_en && !quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 16'($urandom);
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_interval(t);
        items_sent++;
    endtask

    task stop_stream();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits for every owed frame, then for the decoder pipeline to empty,
    // since intervals still in flight may produce nothing on the output.
    task wait_drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_all(logic [15:0] hb, logic [15:0] hg, logic [15:0] bb,
                   logic [15:0] one, logic [15:0] zero, logic [15:0] tol);
        write_reg(REG_HDR_BURST, hb);
        write_reg(REG_HDR_GAP, hg);
        write_reg(REG_BIT_BURST, bb);
        write_reg(REG_ONE_GAP, one);
        write_reg(REG_ZERO_GAP, zero);
        write_reg(REG_TOLERANCE, tol);
    endtask

    // Window settings for each phase of the run: the reset values, an exact
    // match with zero tolerance, a tolerance that opens every window, nominals
    // at both ends of the range so that the bounds saturate, a random spread,
    // and the reset values again together with writes to the unused indexes.
    task apply_setting(int k);
        int tol;
        int zero;
        case (k)
            1: write_all(16'd9000, 16'd4500, 16'd600, 16'd1700, 16'd550, 16'd0);
            2: write_all(16'd4500, 16'd4500, 16'd560, 16'd1690, 16'd560, 16'hFFFF);
            3: write_all(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd300);
            4: begin
                tol  = $urandom_range(0, 400);
                zero = $urandom_range(100, 3000);
                write_all(16'($urandom_range(2000, 12000)), 16'($urandom_range(1000, 8000)),
                          16'($urandom_range(100, 3000)),
                          16'(zero + 2 * tol + $urandom_range(1, 2000)),
                          16'(zero), 16'(tol));
            end
            5: begin
                write_reg(REG_SPARE_LO, 16'($urandom));
                write_reg(REG_SPARE_HI, 16'($urandom));
                write_all(RST_HDR_BURST, RST_HDR_GAP, RST_BIT_BURST,
                          RST_ONE_GAP, RST_ZERO_GAP, RST_TOLERANCE);
            end
            default: ;
        endcase
    endtask

    // Header rejections at both window edges, then a frame whose first slots
    // exercise the bit windows at their bounds, the skip on a bad burst and a
    // gap that matches neither window. The rest of that frame is random.
    task directed_frames();
        send_interval(16'd0);
        send_interval(16'd3999);
        send_interval(16'hFFFF);
        send_interval(16'd4000);
        send_interval(16'd5001);
        send_interval(16'd1234);
        send_interval(16'd5000);
        send_interval(16'd4000);
        send_interval(16'd60);   send_interval(16'd60);
        send_interval(16'd1060); send_interval(16'd1190);
        send_interval(16'd1061);
        send_interval(16'd59);
        send_interval(16'd560);  send_interval(16'd2190);
        send_interval(16'd560);  send_interval(16'd2191);
        send_interval(16'd560);  send_interval(16'd1061);
        send_interval(16'd560);  send_interval(16'd1189);
        send_interval(16'd0);
        send_interval(16'hFFFF);
    endtask

    task send_slot();
        int pick;
        if ($urandom_range(0, 11) == 0) begin
            send_interval(sb.pick_out(sb.regs[REG_BIT_BURST]));
        end else begin
            send_interval(sb.pick_in(sb.regs[REG_BIT_BURST]));
            pick = $urandom_range(0, 19);
            if (pick < 9) send_interval(sb.pick_in(sb.regs[REG_ZERO_GAP]));
            else if (pick < 18) send_interval(sb.pick_in(sb.regs[REG_ONE_GAP]));
            else send_interval(16'($urandom));
        end
    endtask

    // One frame attempt with random content; now and then the header is
    // broken or the frame is cut short.
    task send_frame();
        while (sb.ph != PH_WAKE) send_interval(16'($urandom));
        src_idle_en = ($urandom_range(0, 3) != 0);
        send_interval(16'($urandom));
        if ($urandom_range(0, 9) == 0) begin
            send_interval(sb.pick_out(sb.regs[REG_HDR_BURST]));
            return;
        end
        send_interval(sb.pick_in(sb.regs[REG_HDR_BURST]));
        if ($urandom_range(0, 9) == 0) begin
            send_interval(sb.pick_out(sb.regs[REG_HDR_GAP]));
            return;
        end
        send_interval(sb.pick_in(sb.regs[REG_HDR_GAP]));
        while (sb.ph == PH_BIT_BURST || sb.ph == PH_BIT_GAP) begin
            if ($urandom_range(0, 199) == 0) return;
            if (sb.ph == PH_BIT_GAP) send_interval(16'($urandom));
            else send_slot();
        end
        send_interval(16'($urandom));
    endtask

    initial begin
        int  start_items;
        bit  paused;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_HDR_BURST;
        i_cfg_data    <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < SETTINGS_TOTAL; k++) begin
            if (k > 0) begin
                stop_stream();
                wait_drain();
                apply_setting(k);
            end
            quiet = (k == SETTINGS_TOTAL - 1);
            if (k == 0) directed_frames();
            start_items = items_sent;
            paused = 1'b0;
            while (items_sent - start_items < ITEMS_PER_SETTING) begin
                // Let the sender hold off once until the output side has
                // delivered everything owed.
                if (k == 2 && !paused && items_sent - start_items > ITEMS_PER_SETTING / 2) begin
                    paused = 1'b1;
                    stop_stream();
                    while (sb.pending.size() != 0) @(posedge i_clk);
                end
                // Some stray intervals between frames.
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 5)) send_interval(16'($urandom));
                end
                send_frame();
            end
        end

        stop_stream();
        wait_drain();
        if (sb.pending.size() != 0) begin
            sb.report($sformatf("%0d frame words never arrived", sb.pending.size()));
        end
        if (sb.errors == 0) begin
            $display("ir_pulse_distance_decoder: match");
        end else begin
            $display("ir_pulse_distance_decoder: mismatch");
        end
        $finish;
    end

endmodule
